// ===== src/sdr_pkg.sv =====
// Shared types, width codes and helpers for the signed divide/remainder unit.
// No dependencies; used by sdr_cell and signed_divide_remainder_unit.
package sdr_pkg;

  localparam logic [1:0] OP_W8  = 2'd0;
  localparam logic [1:0] OP_W16 = 2'd1;
  localparam logic [1:0] OP_W32 = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] dividend;
    logic signed [31:0] divisor;
  } in_t;

  typedef struct packed {
    logic signed [31:0] quotient;
    logic signed [31:0] remainder;
    logic               divide_by_zero;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
    logic [1:0]  opcode;
    logic        neg_q;
    logic        neg_r;
    logic        dz;
    logic        ov;
  } work_t;

  function automatic logic [31:0] sext_w(input logic [31:0] x, input logic [1:0] op);
    logic [31:0] res;
    case (op)
      OP_W8:   res = {{24{x[7]}}, x[7:0]};
      OP_W16:  res = {{16{x[15]}}, x[15:0]};
      default: res = x;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] most_neg(input logic [1:0] op);
    logic [31:0] res;
    case (op)
      OP_W8:   res = 32'hFFFF_FF80;
      OP_W16:  res = 32'hFFFF_8000;
      default: res = 32'h8000_0000;
    endcase
    return res;
  endfunction

endpackage

// ===== src/sdr_cell.sv =====
// One restoring-division cell: develops one quotient bit and registers the step.
// Depends on sdr_pkg.
module sdr_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_stall,
  input  sdr_pkg::work_t up_work,
  output logic          dn_valid,
  input  logic          dn_stall,
  output sdr_pkg::work_t dn_work
);

  logic           valid_r;
  sdr_pkg::work_t work_r;
  sdr_pkg::work_t work_nxt;
  logic [32:0]    shifted;
  logic [32:0]    diff;
  logic           ge;

  assign up_stall = valid_r && dn_stall;
  assign dn_valid = valid_r;
  assign dn_work  = work_r;

  always_comb begin
    shifted  = {up_work.rem, up_work.quo[31]};
    diff     = shifted - {1'b0, up_work.dvs};
    ge       = !diff[32];
    work_nxt = up_work;
    work_nxt.rem = ge ? diff[31:0] : shifted[31:0];
    work_nxt.quo = {up_work.quo[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      work_r <= work_nxt;
    end
  end

endmodule

// ===== src/signed_divide_remainder_unit.sv =====
// Top level: operand prep stage, a chain of 32 divide cells, result fixup register.
// Depends on sdr_pkg and sdr_cell.
//
//  channel | ports                          | moves per transfer
//  --------+--------------------------------+-----------------------------
//  input   | in_valid, in_stall, in_data    | opcode, dividend, divisor
//  output  | out_valid, out_stall, out_data | quotient, remainder, flags
//
// One transfer in per cycle while in_stall is low; stages are prep, 32 cells, output register.
// Each cell of the chain resolves one quotient bit, so the chain length sets latency.
// Reset clears every stage valid bit; payload registers are not reset.
// A stage holds only while it is full and the stage after it holds; bubbles close up.
module signed_divide_remainder_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sdr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output sdr_pkg::out_t out_data
);

  logic [32:0]    v;
  logic [32:0]    s;
  sdr_pkg::work_t w [33];

  logic [31:0]    a_sx;
  logic [31:0]    b_sx;
  sdr_pkg::work_t prep_nxt;
  logic           prep_valid_r;
  sdr_pkg::work_t prep_work_r;

  logic           out_valid_r;
  sdr_pkg::out_t  out_data_r;
  sdr_pkg::out_t  out_data_nxt;
  logic [31:0]    q_raw;
  logic [31:0]    r_raw;
  logic           out_hold;

  always_comb begin
    a_sx = sdr_pkg::sext_w(in_data.dividend, in_data.opcode);
    b_sx = sdr_pkg::sext_w(in_data.divisor, in_data.opcode);
    prep_nxt.rem    = '0;
    prep_nxt.quo    = a_sx[31] ? (32'd0 - a_sx) : a_sx;
    prep_nxt.dvs    = b_sx[31] ? (32'd0 - b_sx) : b_sx;
    prep_nxt.opcode = in_data.opcode;
    prep_nxt.neg_q  = a_sx[31] ^ b_sx[31];
    prep_nxt.neg_r  = a_sx[31];
    prep_nxt.dz     = (b_sx == 32'd0);
    prep_nxt.ov     = (a_sx == sdr_pkg::most_neg(in_data.opcode)) && (b_sx == 32'hFFFF_FFFF);
  end

  assign in_stall = prep_valid_r && s[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (!in_stall) begin
      prep_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      prep_work_r <= prep_nxt;
    end
  end

  assign v[0] = prep_valid_r;
  assign w[0] = prep_work_r;

  for (genvar i = 0; i < 32; i++) begin : g_cell
    sdr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v[i]),
      .up_stall (s[i]),
      .up_work  (w[i]),
      .dn_valid (v[i+1]),
      .dn_stall (s[i+1]),
      .dn_work  (w[i+1])
    );
  end

  assign out_hold = out_valid_r && out_stall;
  assign s[32]    = out_hold;

  always_comb begin
    q_raw = w[32].neg_q ? (32'd0 - w[32].quo) : w[32].quo;
    r_raw = w[32].neg_r ? (32'd0 - w[32].rem) : w[32].rem;
    if (w[32].dz) begin
      q_raw = 32'hFFFF_FFFF;
    end
    out_data_nxt.quotient       = sdr_pkg::sext_w(q_raw, w[32].opcode);
    out_data_nxt.remainder      = sdr_pkg::sext_w(r_raw, w[32].opcode);
    out_data_nxt.divide_by_zero = w[32].dz;
    out_data_nxt.overflow       = w[32].ov;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_hold) begin
      out_valid_r <= v[32];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_hold && v[32]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.divide_by_zero && out_data.overflow))
    else $error("divide_by_zero and overflow both set");

  a_dz_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |-> out_data.quotient == 32'hFFFF_FFFF)
    else $error("quotient not all ones on divide by zero");

  a_ov_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> out_data.remainder == 32'd0)
    else $error("remainder not zero on overflow");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v[0] && v[32] && out_valid_r)
    else $error("input stalled while the chain has room");

endmodule
